/* hw/rtl/dsp_pkg.sv */
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types and constants for the shortest path engine: function and
// error codes, result width and the sequencer state type.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int unsigned DIST_W = 22;
  localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

  localparam int unsigned LIMIT_W = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd63;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_ADD2    = 11'b000_0000_0010,
    S_INIT    = 11'b000_0000_0100,
    S_SCAN    = 11'b000_0000_1000,
    S_SETTLE  = 11'b000_0001_0000,
    S_E_RD    = 11'b000_0010_0000,
    S_E_TST   = 11'b000_0100_0000,
    S_N_CMP   = 11'b000_1000_0000,
    S_RD_DEST = 11'b001_0000_0000,
    S_FIN     = 11'b010_0000_0000,
    S_RESP    = 11'b100_0000_0000
  } state_t;

endpackage

/* hw/rtl/dijkstra_shortest_path.sv */
// ----------------------------------------------------------------------------
// dijkstra_shortest_path
// Add-edge items fill an edge table; query items run a single-source search
// with a linear minimum scan and report the distance to one node.
// Add edge: an undirected edge also writes its reverse in S_ADD2. Query: an
// init pass writes nodes 0..L; then per settled node a minimum scan of nodes
// 0..L and a pass over all stored edges relaxing those that leave that node;
// last the dest node is read. L is the effective node limit; one node memory
// port bounds the scan, one edge port the relaxation. One item at a time;
// stall is high until the result moves to the output register. Reset clears
// edge count, node_limit (to 63) and the handshakes; no clearing pass.
// ----------------------------------------------------------------------------
module dijkstra_shortest_path #(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned MAX_EDGES   = 256,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,

  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [5:0]  edge_from,
  input  logic [5:0]  edge_to,
  input  logic [15:0] edge_weight,
  input  logic        edge_directed,
  input  logic [5:0]  query_source,
  input  logic [5:0]  query_dest,

  output logic        result_valid,
  input  logic        result_stall,
  output logic [21:0] distance,
  output logic        reachable,
  output logic [1:0]  error
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned NCW = NW + 1;
  localparam int unsigned EW  = $clog2(MAX_EDGES);
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned DW  = WEIGHT_BITS + NW;
  localparam int unsigned CW  = (DW > dsp_pkg::DIST_W) ? DW : dsp_pkg::DIST_W;

  typedef struct packed {
    logic [NW-1:0]          from;
    logic [NW-1:0]          to;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic          settled;
    logic          inf;
    logic [DW-1:0] cost;
  } node_t;

  edge_t edge_mem [MAX_EDGES];
  node_t node_mem [MAX_NODES];

  dsp_pkg::state_t state;

  logic [dsp_pkg::LIMIT_W-1:0] node_limit;
  logic [ECW-1:0]              edge_count;
  logic [NW-1:0]               lim;
  logic [NW-1:0]               src;
  logic [NW-1:0]               dest;
  edge_t                       add_ent;
  logic [NCW-1:0]              idx;
  logic                        sq_valid;
  logic [NW-1:0]               sq_idx;
  logic                        found;
  logic [NW-1:0]               best;
  logic [DW-1:0]               best_dist;
  logic [ECW-1:0]              eidx;
  edge_t                       edge_q;
  node_t                       node_q;
  logic [dsp_pkg::DIST_W-1:0]  res_distance;
  logic                        res_reachable;
  logic [1:0]                  res_error;

  logic                        item_fire;
  logic [NW-1:0]               eff_lim;
  logic                        q_bad;
  logic                        e_bad;
  logic                        e_full;
  logic [1:0]                  need;
  logic                        match;
  logic [DW-1:0]               cand;
  logic                        better;
  logic [dsp_pkg::DIST_W-1:0]  dist_clamp;

  logic                        edge_we;
  logic [EW-1:0]               edge_waddr;
  edge_t                       edge_wdata;
  logic                        edge_re;
  logic [EW-1:0]               edge_raddr;
  logic                        node_we;
  logic [NW-1:0]               node_waddr;
  node_t                       node_wdata;
  logic                        node_re;
  logic [NW-1:0]               node_raddr;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != dsp_pkg::S_IDLE);
  assign item_fire  = item_valid && !item_stall;

  assign eff_lim = (32'(node_limit) > 32'(MAX_NODES - 1)) ? NW'(MAX_NODES - 1)
                                                          : NW'(node_limit);
  assign q_bad   = (32'(query_source) > 32'(eff_lim)) || (32'(query_dest) > 32'(eff_lim));
  assign e_bad   = (32'(edge_from) >= 32'(MAX_NODES)) || (32'(edge_to) >= 32'(MAX_NODES));
  assign need    = edge_directed ? 2'd1 : 2'd2;
  assign e_full  = (32'(edge_count) + 32'(need)) > 32'(MAX_EDGES);

  assign match  = (edge_q.from == best) && (edge_q.to <= lim);
  assign cand   = best_dist + DW'(edge_q.weight);
  assign better = node_q.inf || (cand < node_q.cost);
  assign dist_clamp = (CW'(node_q.cost) > CW'(dsp_pkg::DIST_MAX)) ? dsp_pkg::DIST_MAX
                                                                  : dsp_pkg::DIST_W'(node_q.cost);

  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = edge_count[EW-1:0];
    edge_wdata = add_ent;
    edge_re    = 1'b0;
    edge_raddr = eidx[EW-1:0];
    node_we    = 1'b0;
    node_waddr = idx[NW-1:0];
    node_wdata = '{settled: 1'b0, inf: (idx[NW-1:0] != src), cost: '0};
    node_re    = 1'b0;
    node_raddr = idx[NW-1:0];
    unique case (state)
      dsp_pkg::S_IDLE: begin
        if (item_fire && (func == dsp_pkg::FUNC_ADD) && !e_bad && !e_full) begin
          edge_we    = 1'b1;
          edge_wdata = '{from: NW'(edge_from), to: NW'(edge_to),
                         weight: WEIGHT_BITS'(edge_weight)};
        end
      end
      dsp_pkg::S_ADD2: begin
        edge_we = 1'b1;
      end
      dsp_pkg::S_INIT: begin
        node_we = 1'b1;
      end
      dsp_pkg::S_SCAN: begin
        node_re = (idx <= {1'b0, lim});
      end
      dsp_pkg::S_SETTLE: begin
        node_we    = 1'b1;
        node_waddr = best;
        node_wdata = '{settled: 1'b1, inf: 1'b0, cost: best_dist};
      end
      dsp_pkg::S_E_RD: begin
        edge_re = (eidx < edge_count);
      end
      dsp_pkg::S_E_TST: begin
        if (match) begin
          node_re    = 1'b1;
          node_raddr = edge_q.to;
        end else begin
          edge_re = (eidx < edge_count);
        end
      end
      dsp_pkg::S_N_CMP: begin
        node_we    = better;
        node_waddr = edge_q.to;
        node_wdata = '{settled: node_q.settled, inf: 1'b0, cost: cand};
      end
      dsp_pkg::S_RD_DEST: begin
        node_re    = 1'b1;
        node_raddr = dest;
      end
      dsp_pkg::S_FIN, dsp_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    if (edge_re) begin
      edge_q <= edge_mem[edge_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_q <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dsp_pkg::S_IDLE;
      node_limit   <= dsp_pkg::LIMIT_RESET;
      edge_count   <= '0;
      result_valid <= 1'b0;
      sq_valid     <= 1'b0;
      found        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_limit <= cfg_data;
      end
      if (result_valid && !result_stall && (state != dsp_pkg::S_RESP)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        dsp_pkg::S_IDLE: begin
          if (item_fire) begin
            res_distance  <= '0;
            res_reachable <= 1'b0;
            if (func == dsp_pkg::FUNC_QUERY) begin
              if (q_bad) begin
                res_error <= dsp_pkg::ERR_RANGE;
                state     <= dsp_pkg::S_RESP;
              end else begin
                lim   <= eff_lim;
                src   <= NW'(query_source);
                dest  <= NW'(query_dest);
                idx   <= '0;
                state <= dsp_pkg::S_INIT;
              end
            end else if (e_bad) begin
              res_error <= dsp_pkg::ERR_RANGE;
              state     <= dsp_pkg::S_RESP;
            end else if (e_full) begin
              res_error <= dsp_pkg::ERR_FULL;
              state     <= dsp_pkg::S_RESP;
            end else begin
              res_error  <= dsp_pkg::ERR_NONE;
              edge_count <= edge_count + 1'b1;
              add_ent    <= '{from: NW'(edge_to), to: NW'(edge_from),
                              weight: WEIGHT_BITS'(edge_weight)};
              state      <= edge_directed ? dsp_pkg::S_RESP : dsp_pkg::S_ADD2;
            end
          end
        end
        dsp_pkg::S_ADD2: begin
          edge_count <= edge_count + 1'b1;
          state      <= dsp_pkg::S_RESP;
        end
        dsp_pkg::S_INIT: begin
          if (idx == {1'b0, lim}) begin
            idx      <= '0;
            found    <= 1'b0;
            sq_valid <= 1'b0;
            state    <= dsp_pkg::S_SCAN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        dsp_pkg::S_SCAN: begin
          sq_valid <= node_re;
          sq_idx   <= idx[NW-1:0];
          if (node_re) begin
            idx <= idx + 1'b1;
          end
          if (sq_valid && !node_q.settled && !node_q.inf &&
              (!found || (node_q.cost < best_dist))) begin
            best      <= sq_idx;
            best_dist <= node_q.cost;
            found     <= 1'b1;
          end
          if (!node_re && !sq_valid) begin
            state <= found ? dsp_pkg::S_SETTLE : dsp_pkg::S_RD_DEST;
          end
        end
        dsp_pkg::S_SETTLE: begin
          eidx  <= '0;
          state <= dsp_pkg::S_E_RD;
        end
        dsp_pkg::S_E_RD: begin
          if (edge_re) begin
            eidx  <= eidx + 1'b1;
            state <= dsp_pkg::S_E_TST;
          end else begin
            idx      <= '0;
            found    <= 1'b0;
            sq_valid <= 1'b0;
            state    <= dsp_pkg::S_SCAN;
          end
        end
        dsp_pkg::S_E_TST: begin
          if (match) begin
            state <= dsp_pkg::S_N_CMP;
          end else if (edge_re) begin
            eidx <= eidx + 1'b1;
          end else begin
            idx      <= '0;
            found    <= 1'b0;
            sq_valid <= 1'b0;
            state    <= dsp_pkg::S_SCAN;
          end
        end
        dsp_pkg::S_N_CMP: begin
          state <= dsp_pkg::S_E_RD;
        end
        dsp_pkg::S_RD_DEST: begin
          state <= dsp_pkg::S_FIN;
        end
        dsp_pkg::S_FIN: begin
          res_reachable <= !node_q.inf;
          res_distance  <= node_q.inf ? '0 : dist_clamp;
          res_error     <= dsp_pkg::ERR_NONE;
          state         <= dsp_pkg::S_RESP;
        end
        dsp_pkg::S_RESP: begin
          if (!result_valid || !result_stall) begin
            distance     <= res_distance;
            reachable    <= res_reachable;
            error        <= res_error;
            result_valid <= 1'b1;
            state        <= dsp_pkg::S_IDLE;
          end
        end
        default: begin
          state <= dsp_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule
